FILE: hw/rtl/u8d_pkg.sv
// Shared types and constants for the UTF-8 code point decoder.
// No dependencies; every other file of the block refers to this package.
package u8d_pkg;

   // Window geometry and result width.
   localparam int WindowBytes = 6;
   localparam int NumLanes    = WindowBytes - 1;
   localparam int CpWidth     = 32;
   localparam int CountWidth  = 3;

   // Lead byte class boundaries.
   localparam logic [7:0] LeadTwo   = 8'hC0;
   localparam logic [7:0] LeadThree = 8'hE0;
   localparam logic [7:0] LeadFour  = 8'hF0;
   localparam logic [7:0] LeadFive  = 8'hF8;
   localparam logic [7:0] LeadSix   = 8'hFC;
   localparam logic [7:0] LeadCont  = 8'h80;

   // Payload masks for lead and continuation bytes.
   localparam logic [7:0] MaskCont  = 8'h3F;
   localparam logic [7:0] MaskTwo   = 8'h1F;
   localparam logic [7:0] MaskThree = 8'h0F;
   localparam logic [7:0] MaskFour  = 8'h07;
   localparam logic [7:0] MaskFive  = 8'h03;

   // Result status codes.
   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_EMPTY    = 2'd1,
      ST_BAD_LEAD = 2'd2,
      ST_TRUNC    = 2'd3
   } status_type;

   // What the lead byte decode hands to the lanes and the merge stage.
   typedef struct packed {
      logic [CountWidth-1:0] need;
      status_type            status;
      logic [CpWidth-1:0]    lead_bits;
   } lead_info_type;

endpackage

FILE: hw/rtl/u8d_lead.sv
// Lead byte classification: sequence length, status and placed lead payload.
// Depends on u8d_pkg.
module u8d_lead (
   input  logic [7:0]                      lead_byte,
   input  logic [u8d_pkg::CountWidth-1:0]  avail,
   output u8d_pkg::lead_info_type          info
);

   logic [u8d_pkg::CountWidth-1:0] avail_sat;
   logic [u8d_pkg::CountWidth-1:0] need;
   logic [7:0]                     masked;
   logic [4:0]                     shift_amt;
   logic                           bad_lead;

   // A count of seven saturates to the window size.
   assign avail_sat = (avail > u8d_pkg::CountWidth'(u8d_pkg::WindowBytes))
                      ? u8d_pkg::CountWidth'(u8d_pkg::WindowBytes) : avail;

   // Pick sequence length, payload mask and payload position from the lead byte.
   always_comb begin
      bad_lead  = 1'b0;
      need      = 3'd1;
      masked    = lead_byte;
      shift_amt = 5'd0;
      priority if (lead_byte < u8d_pkg::LeadCont) begin
         need      = 3'd1;
         masked    = lead_byte;
         shift_amt = 5'd0;
      end else if (lead_byte < u8d_pkg::LeadTwo) begin
         bad_lead  = 1'b1;
         need      = 3'd0;
      end else if (lead_byte < u8d_pkg::LeadThree) begin
         need      = 3'd2;
         masked    = lead_byte & u8d_pkg::MaskTwo;
         shift_amt = 5'd6;
      end else if (lead_byte < u8d_pkg::LeadFour) begin
         need      = 3'd3;
         masked    = lead_byte & u8d_pkg::MaskThree;
         shift_amt = 5'd12;
      end else if (lead_byte < u8d_pkg::LeadFive) begin
         need      = 3'd4;
         masked    = lead_byte & u8d_pkg::MaskFour;
         shift_amt = 5'd18;
      end else if (lead_byte < u8d_pkg::LeadSix) begin
         need      = 3'd5;
         masked    = lead_byte & u8d_pkg::MaskFive;
         shift_amt = 5'd24;
      end else begin
         need      = 3'd6;
         masked    = lead_byte & u8d_pkg::MaskFive;
         shift_amt = 5'd30;
      end
   end

   // Status priority follows the decode order: empty, bad lead, then truncation.
   always_comb begin
      info.need      = need;
      info.lead_bits = u8d_pkg::CpWidth'(masked) << shift_amt;
      priority if (avail_sat == '0) begin
         info.status = u8d_pkg::ST_EMPTY;
      end else if (bad_lead) begin
         info.status = u8d_pkg::ST_BAD_LEAD;
      end else if (avail_sat < need) begin
         info.status = u8d_pkg::ST_TRUNC;
      end else begin
         info.status = u8d_pkg::ST_OK;
      end
   end

endmodule

FILE: hw/rtl/u8d_lane.sv
// One continuation byte lane: places six payload bits by the sequence length.
// Depends on u8d_pkg.
module u8d_lane #(
   parameter int LaneIndex = 1
) (
   input  logic [7:0]                     cont_byte,
   input  logic [u8d_pkg::CountWidth-1:0] need,
   output logic [u8d_pkg::CpWidth-1:0]    contrib
);

   logic                           in_seq;
   logic [u8d_pkg::CountWidth-1:0] slots_after;
   logic [4:0]                     shift_amt;

   // The byte belongs to the sequence only when its position is below the length.
   assign in_seq      = need > u8d_pkg::CountWidth'(LaneIndex);
   assign slots_after = need - u8d_pkg::CountWidth'(LaneIndex) - 3'd1;
   assign shift_amt   = 5'(slots_after) * 5'd6;

   // Six payload bits, shifted into place, or nothing outside the sequence.
   assign contrib = in_seq
      ? (u8d_pkg::CpWidth'(cont_byte & u8d_pkg::MaskCont) << shift_amt)
      : '0;

endmodule

FILE: hw/rtl/u8d_merge.sv
// Merge stage: combines lead payload and lane contributions into the result.
// Depends on u8d_pkg.
module u8d_merge (
   input  u8d_pkg::lead_info_type          info,
   input  logic [u8d_pkg::CpWidth-1:0]     lane_bits [u8d_pkg::NumLanes],
   output logic [u8d_pkg::CpWidth-1:0]     char_value,
   output logic [u8d_pkg::CountWidth-1:0]  consumed,
   output logic [1:0]                      status
);

   logic [u8d_pkg::CpWidth-1:0] combined;

   // Lanes never overlap, so an OR assembles the code point.
   always_comb begin
      combined = info.lead_bits;
      for (int i = 0; i < u8d_pkg::NumLanes; i++) begin
         combined = combined | lane_bits[i];
      end
   end

   // Any error status clears the value and the length.
   always_comb begin
      status = info.status;
      if (info.status == u8d_pkg::ST_OK) begin
         char_value = combined;
         consumed   = info.need;
      end else begin
         char_value = '0;
         consumed   = '0;
      end
   end

endmodule

FILE: hw/rtl/utf8_code_point_decoder_core.sv
// UTF-8 code point decoder core: one six-byte window in, one result out.
// A request is registered in the first stage, its result in the output register.
// Throughput: one transaction per cycle unless rsp_ready stalls the output; a lead
// decoder and five byte lanes work in the first stage, an OR merge fills the output
// register in the second. Reset (synchronous, active high) empties both stages;
// data registers keep values. Depends on u8d_pkg, u8d_lead, u8d_lane and u8d_merge.
module utf8_code_point_decoder_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [7:0]                     req_byte0,
   input  logic [7:0]                     req_byte1,
   input  logic [7:0]                     req_byte2,
   input  logic [7:0]                     req_byte3,
   input  logic [7:0]                     req_byte4,
   input  logic [7:0]                     req_byte5,
   input  logic [u8d_pkg::CountWidth-1:0] req_avail,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [u8d_pkg::CpWidth-1:0]    rsp_char,
   output logic [u8d_pkg::CountWidth-1:0] rsp_consumed,
   output logic [1:0]                     rsp_status
);

   logic [7:0]                     cont_bytes [u8d_pkg::NumLanes];
   u8d_pkg::lead_info_type         lead_info;
   logic [u8d_pkg::CpWidth-1:0]    lane_out [u8d_pkg::NumLanes];

   logic                           s1_valid_ff;
   logic                           s1_valid_in;
   u8d_pkg::lead_info_type         s1_info_ff;
   logic [u8d_pkg::CpWidth-1:0]    s1_lanes_ff [u8d_pkg::NumLanes];

   logic                           out_valid_ff;
   logic                           out_valid_in;
   logic [u8d_pkg::CpWidth-1:0]    out_cp_ff;
   logic [u8d_pkg::CpWidth-1:0]    out_cp_in;
   logic [u8d_pkg::CountWidth-1:0] out_consumed_ff;
   logic [u8d_pkg::CountWidth-1:0] out_consumed_in;
   logic [1:0]                     out_status_ff;
   logic [1:0]                     out_status_in;

   logic                           out_load;
   logic                           s1_load;

   // Stage enables: each stage moves when the one after it has room.
   assign out_load  = !out_valid_ff || rsp_ready;
   assign s1_load   = !s1_valid_ff || out_load;
   assign req_ready = s1_load;

   assign cont_bytes[0] = req_byte1;
   assign cont_bytes[1] = req_byte2;
   assign cont_bytes[2] = req_byte3;
   assign cont_bytes[3] = req_byte4;
   assign cont_bytes[4] = req_byte5;

   // Lead byte decode.
   u8d_lead u_lead (
      .lead_byte (req_byte0),
      .avail     (req_avail),
      .info      (lead_info)
   );

   // One lane per continuation byte position.
   for (genvar g = 0; g < u8d_pkg::NumLanes; g++) begin : g_lane
      u8d_lane #(
         .LaneIndex (g + 1)
      ) u_lane (
         .cont_byte (cont_bytes[g]),
         .need      (lead_info.need),
         .contrib   (lane_out[g])
      );
   end

   // First stage register: lead info and lane contributions.
   assign s1_valid_in = s1_load ? req_valid : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load && req_valid) begin
         s1_info_ff <= lead_info;
         for (int i = 0; i < u8d_pkg::NumLanes; i++) begin
            s1_lanes_ff[i] <= lane_out[i];
         end
      end
   end

   // Merge stage into the output register.
   u8d_merge u_merge (
      .info       (s1_info_ff),
      .lane_bits  (s1_lanes_ff),
      .char_value (out_cp_in),
      .consumed   (out_consumed_in),
      .status     (out_status_in)
   );

   assign out_valid_in = out_load ? s1_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load && s1_valid_ff) begin
         out_cp_ff       <= out_cp_in;
         out_consumed_ff <= out_consumed_in;
         out_status_ff   <= out_status_in;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_char     = out_cp_ff;
   assign rsp_consumed = out_consumed_ff;
   assign rsp_status   = out_status_ff;

endmodule
